FILE: rtl/cqst_pkg.sv
// Shared types, constants and helpers for the crank quadrant Schmitt trigger unit.
package cqst_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned CfgW  = 15;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned InW   = 48;
  localparam int unsigned OutW  = 40;
  localparam int unsigned UserW = 2;

  localparam logic [IdxW-1:0] REG_BIAS_X          = 3'd0;
  localparam logic [IdxW-1:0] REG_BIAS_Z          = 3'd1;
  localparam logic [IdxW-1:0] REG_COS_THETA       = 3'd2;
  localparam logic [IdxW-1:0] REG_SIN_THETA       = 3'd3;
  localparam logic [IdxW-1:0] REG_Z_OFFSET        = 3'd4;
  localparam logic [IdxW-1:0] REG_NOISE_THRESHOLD = 3'd5;
  localparam logic [IdxW-1:0] REG_TICK_SECONDS    = 3'd6;

  localparam logic signed [DataW-1:0] S15_MAX        = 16'sh7FFF;
  localparam logic signed [DataW-1:0] S15_MIN        = 16'sh8000;
  localparam logic signed [DataW-1:0] PHASE_NEG_ONE  = 16'sh8000;
  localparam logic signed [DataW-1:0] PHASE_NEG_HALF = 16'shC000;
  localparam logic signed [DataW-1:0] PHASE_ZERO     = 16'sh0000;
  localparam logic signed [DataW-1:0] PHASE_POS_HALF = 16'sh4000;

  localparam logic [CfgW-1:0] NOISE_RESET = 15'd328;
  localparam logic [CfgW-1:0] TICK_RESET  = 15'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_MUL,
    ST_FLAG,
    ST_SECS,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       sub;
    logic       mul;
    logic [1:0] mul_sel;
    logic       flag;
    logic       secs;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic rate_needed;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [DataW:0] v);
    logic signed [DataW-1:0] r;
    if (v > 17'sd32767) begin
      r = S15_MAX;
    end else if (v < -17'sd32768) begin
      r = S15_MIN;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/cqst_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module cqst_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cqst_pkg::DataW-1:0]    dividend_hi,
  input  logic [cqst_pkg::DataW-1:0]    dividend_lo,
  input  logic [cqst_pkg::CfgW-1:0]     divisor,
  output logic                          done,
  output logic [cqst_pkg::DataW-1:0]    quotient
);

  logic [cqst_pkg::DataW-1:0] rem_r, rem_nxt;
  logic [cqst_pkg::DataW-1:0] lo_r, lo_nxt;
  logic [3:0]                 cnt_r;
  logic                       busy_r;
  logic [cqst_pkg::DataW:0]   trial;
  logic                       ge;

  always_comb begin
    trial   = {rem_r, lo_r[cqst_pkg::DataW-1]};
    ge      = (trial >= {2'b00, divisor});
    rem_nxt = ge ? 16'(trial - {2'b00, divisor}) : trial[cqst_pkg::DataW-1:0];
    lo_nxt  = {lo_r[cqst_pkg::DataW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd15;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend_hi;
      lo_r  <= dividend_lo;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign done     = busy_r && (cnt_r == 4'd0);
  assign quotient = lo_r;

endmodule

FILE: rtl/cqst_dp.sv
// Datapath: registers, bias removal, rotation, Schmitt flags, phase and rate.
module cqst_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cqst_pkg::IdxW-1:0]     cfg_index,
  input  logic [cqst_pkg::DataW-1:0]    cfg_wdata,
  input  logic [cqst_pkg::InW-1:0]      in_tdata,
  input  cqst_pkg::cmd_t                cmd,
  output cqst_pkg::stat_t               stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cqst_pkg::OutW-1:0]     out_tdata,
  output logic [cqst_pkg::UserW-1:0]    out_tuser
);

  localparam int unsigned W = cqst_pkg::DataW;

  logic signed [W-1:0]                bias_x_r, bias_z_r, cos_r, sin_r;
  logic [cqst_pkg::CfgW-1:0]          z_off_r, thr_r, tick_r;

  logic signed [W-1:0]                sx_r, sz_r, ux_r, uz_r;
  logic [W-1:0]                       ts_r;
  logic signed [W-1:0]                m_r [4];

  logic                               x_low_r, z_low_r;
  logic [W-1:0]                       last_phase_r, last_time_r;
  logic                               trig_r, rv_r;
  logic signed [W-1:0]                phase_r, diff_r;
  logic [W-1:0]                       dt_r;
  logic [cqst_pkg::CfgW-1:0]          secs_r;

  logic                               out_valid_r;
  logic                               o_trig_r, o_rv_r, o_x_r, o_z_r;
  logic signed [W-1:0]                o_phase_r, o_rate_r;

  logic signed [W-1:0]                op_a, op_b;
  logic signed [2*W-1:0]              prod;
  logic signed [W:0]                  prod_q;
  logic signed [W-1:0]                ux_nxt, uz_nxt, lx, lz, vz;
  logic signed [W:0]                  neg_thr;
  logic                               x_above, x_below, z_above, z_below;
  logic                               nx, nz, cx, cz, trig;
  logic signed [W-1:0]                phase, diff;
  logic [30:0]                        secs_full;
  logic [cqst_pkg::CfgW-1:0]          secs_nxt;
  logic [W:0]                         mag;
  logic                               div_done;
  logic [W-1:0]                       quot;
  logic                               sat_big;
  logic signed [W-1:0]                rate_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r <= '0;
      bias_z_r <= '0;
      cos_r    <= cqst_pkg::S15_MAX;
      sin_r    <= '0;
      z_off_r  <= '0;
      thr_r    <= cqst_pkg::NOISE_RESET;
      tick_r   <= cqst_pkg::TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cqst_pkg::REG_BIAS_X:          bias_x_r <= cfg_wdata;
        cqst_pkg::REG_BIAS_Z:          bias_z_r <= cfg_wdata;
        cqst_pkg::REG_COS_THETA:       cos_r    <= cfg_wdata;
        cqst_pkg::REG_SIN_THETA:       sin_r    <= cfg_wdata;
        cqst_pkg::REG_Z_OFFSET:        z_off_r  <= cfg_wdata[cqst_pkg::CfgW-1:0];
        cqst_pkg::REG_NOISE_THRESHOLD: thr_r    <= cfg_wdata[cqst_pkg::CfgW-1:0];
        cqst_pkg::REG_TICK_SECONDS:    tick_r   <= cfg_wdata[cqst_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // bias removal
  always_comb begin
    ux_nxt = cqst_pkg::sat16(17'(sx_r) - 17'(bias_x_r));
    uz_nxt = cqst_pkg::sat16(17'(sz_r) - 17'(bias_z_r));
  end

  // shared s.15 multiplier, floor then saturate
  always_comb begin
    case (cmd.mul_sel)
      2'd0:    begin op_a = cos_r; op_b = ux_r; end
      2'd1:    begin op_a = sin_r; op_b = uz_r; end
      2'd2:    begin op_a = cos_r; op_b = uz_r; end
      default: begin op_a = sin_r; op_b = ux_r; end
    endcase
    prod   = op_a * op_b;
    prod_q = prod[2*W-1:W-1];
  end

  // rotation, Schmitt flags and phase
  always_comb begin
    lx      = cqst_pkg::sat16(17'(m_r[0]) - 17'(m_r[1]));
    lz      = cqst_pkg::sat16(17'(m_r[2]) + 17'(m_r[3]));
    vz      = cqst_pkg::sat16(17'(lz) + $signed({2'b00, z_off_r}));
    // full-scale band: -1.0 saturates to the band edge and stays inside
    neg_thr = (thr_r == '1) ? -17'sd32768 : -$signed({2'b00, thr_r});
    x_above = 17'(lx) > $signed({2'b00, thr_r});
    x_below = 17'(lx) < neg_thr;
    z_above = 17'(vz) > $signed({2'b00, thr_r});
    z_below = 17'(vz) < neg_thr;
    nx      = x_low_r ? !x_above : x_below;
    nz      = z_low_r ? !z_above : z_below;
    cx      = nx ^ x_low_r;
    cz      = nz ^ z_low_r;
    trig    = cx | cz;
    if (cx) begin
      phase = nz ? cqst_pkg::PHASE_ZERO : cqst_pkg::PHASE_NEG_ONE;
    end else begin
      phase = nx ? cqst_pkg::PHASE_NEG_HALF : cqst_pkg::PHASE_POS_HALF;
    end
    diff = phase - $signed(last_phase_r);
  end

  // elapsed seconds and rate
  always_comb begin
    secs_full = dt_r * tick_r;
    secs_nxt  = (secs_full > 31'd32767) ? 15'h7FFF : secs_full[cqst_pkg::CfgW-1:0];
    mag       = diff_r[W-1] ? 17'(-17'(diff_r)) : 17'(diff_r);
    sat_big   = (secs_r == '0) || (mag >= {1'b0, secs_r, 1'b0});
    if (!diff_r[W-1]) begin
      rate_nxt = (sat_big || quot[W-1]) ? cqst_pkg::S15_MAX : $signed(quot);
    end else if (sat_big || (quot > 16'h8000)) begin
      rate_nxt = cqst_pkg::S15_MIN;
    end else begin
      rate_nxt = -$signed(quot);
    end
  end

  cqst_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cmd.div_start),
    .dividend_hi (mag[W:1]),
    .dividend_lo ({mag[0], 15'd0}),
    .divisor     (secs_r),
    .done        (div_done),
    .quotient    (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= in_tdata[W-1:0];
      sz_r <= in_tdata[2*W-1:W];
      ts_r <= in_tdata[3*W-1:2*W];
    end
    if (cmd.sub) begin
      ux_r <= ux_nxt;
      uz_r <= uz_nxt;
    end
    if (cmd.mul) begin
      m_r[cmd.mul_sel] <= cqst_pkg::sat16(prod_q);
    end
    if (cmd.flag) begin
      trig_r  <= trig;
      phase_r <= trig ? phase : cqst_pkg::PHASE_ZERO;
      rv_r    <= trig && (diff != '0);
      diff_r  <= diff;
      dt_r    <= ts_r - last_time_r;
    end
    if (cmd.secs) begin
      secs_r <= secs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r      <= 1'b0;
      z_low_r      <= 1'b0;
      last_phase_r <= '0;
      last_time_r  <= '0;
    end else if (cmd.flag) begin
      x_low_r <= nx;
      z_low_r <= nz;
      if (trig) begin
        last_phase_r <= phase;
        last_time_r  <= ts_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_trig_r  <= trig_r;
      o_rv_r    <= rv_r;
      o_phase_r <= phase_r;
      o_rate_r  <= rv_r ? rate_nxt : '0;
      o_x_r     <= x_low_r;
      o_z_r     <= z_low_r;
    end
  end

  assign stat.rate_needed = trig && (diff != '0);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_z_r, o_x_r, o_rate_r, o_phase_r};
  assign out_tuser  = {o_rv_r, o_trig_r};

endmodule

FILE: rtl/cqst_ctrl.sv
// Controller: sequences one sample through the datapath.
module cqst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cqst_pkg::stat_t   stat,
  output cqst_pkg::cmd_t    cmd
);

  cqst_pkg::state_t state_r, state_nxt;
  logic [1:0]       mul_cnt_r, mul_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cqst_pkg::ST_IDLE;
      mul_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= mul_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mul_cnt_nxt = mul_cnt_r;
    cmd         = '0;
    cmd.mul_sel = mul_cnt_r;
    in_tready   = 1'b0;
    case (state_r)
      cqst_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = cqst_pkg::ST_SUB;
        end
      end
      cqst_pkg::ST_SUB: begin
        cmd.sub     = 1'b1;
        mul_cnt_nxt = '0;
        state_nxt   = cqst_pkg::ST_MUL;
      end
      cqst_pkg::ST_MUL: begin
        cmd.mul     = 1'b1;
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        if (mul_cnt_r == 2'd3) begin
          state_nxt = cqst_pkg::ST_FLAG;
        end
      end
      cqst_pkg::ST_FLAG: begin
        cmd.flag  = 1'b1;
        state_nxt = stat.rate_needed ? cqst_pkg::ST_SECS : cqst_pkg::ST_OUT;
      end
      cqst_pkg::ST_SECS: begin
        cmd.secs      = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = cqst_pkg::ST_DIV;
      end
      cqst_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = cqst_pkg::ST_OUT;
        end
      end
      cqst_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cqst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cqst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/crank_quadrant_schmitt_trigger_unit.sv
// Top level of the crank quadrant Schmitt trigger unit.
//
// Input stream: one word per accelerometer sample (x, z, tick timestamp).
// Output stream: one word per sample with the Schmitt flags, and, when a
// flag changed, the quadrant phase and, when the phase moved, its rate.
// Configuration: write cfg_we with cfg_index and cfg_wdata while idle.
//
// Steps: the accepting cycle, bias removal, four products through one
// shared multiplier, the flag update and the output load. A rate adds
// the elapsed-seconds step and the bit-serial divider before the
// output load, which waits until the output register is free.
// in_tready is high only while no sample is in work.
//
// Reset (synchronous, rst_n low) restores register defaults, clears the
// flags, the last phase and the last timestamp and empties the output.
// A stalled receiver holds the output word; one further sample is worked
// up to the output stage and then waits there until the word is taken.
module crank_quadrant_schmitt_trigger_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cqst_pkg::IdxW-1:0]     cfg_index,
  input  logic [cqst_pkg::DataW-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // sample_x[15:0], sample_z[31:16], timestamp[47:32]
  input  logic [cqst_pkg::InW-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // phase[15:0], phase_rate[31:16], x_flag[32], z_flag[33], zero fill
  output logic [cqst_pkg::OutW-1:0]     out_tdata,
  // triggered[0], rate_valid[1]
  output logic [cqst_pkg::UserW-1:0]    out_tuser
);

  cqst_pkg::cmd_t  cmd;
  cqst_pkg::stat_t stat;

  cqst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cqst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/cqst_checker.sv
// Port-level checker for the crank quadrant Schmitt trigger unit, with its bind.
module cqst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cqst_pkg::OutW-1:0]     out_tdata,
  input logic [cqst_pkg::UserW-1:0]    out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output not empty after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

  a_no_trig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1] && (out_tdata[31:0] == 32'd0))
    else $error("phase or rate set without trigger");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] == 16'h8000) || (out_tdata[15:0] == 16'hC000) ||
                   (out_tdata[15:0] == 16'h0000) || (out_tdata[15:0] == 16'h4000))
    else $error("phase outside the four quadrants");

endmodule

bind crank_quadrant_schmitt_trigger_unit cqst_checker u_cqst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the crank quadrant Schmitt trigger unit.
module tb;
  import cqst_pkg::*;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned BATCH_WORDS   = 250;
  localparam int unsigned BATCHES       = 7;
  localparam int unsigned REG_COUNT     = 7;
  localparam logic [IdxW-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {BAND_INSIDE, BAND_ABOVE, BAND_BELOW} band_t;
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic                    triggered;
    logic signed [DataW-1:0] phase;
    logic                    rate_valid;
    logic signed [DataW-1:0] rate;
    logic                    x_flag;
    logic                    z_flag;
  } quadrant_word_t;

  typedef struct {
    row_kind_t               kind;
    logic [IdxW-1:0]         reg_idx;
    logic [DataW-1:0]        value;
    logic signed [DataW-1:0] sx;
    logic signed [DataW-1:0] sz;
    logic [DataW-1:0]        stamp;
    bit                      typed;
    quadrant_word_t          want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [DataW-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // sample_x[15:0], sample_z[31:16], timestamp[47:32]
  logic [InW-1:0]   in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // phase[15:0], phase_rate[31:16], x_flag[32], z_flag[33], zero fill
  logic [OutW-1:0]  out_tdata;
  // triggered[0], rate_valid[1]
  logic [UserW-1:0] out_tuser;

  // predictor copy of the registers and of the trigger state
  logic signed [DataW-1:0] bias_x_p = '0;
  logic signed [DataW-1:0] bias_z_p = '0;
  logic signed [DataW-1:0] cos_p = S15_MAX;
  logic signed [DataW-1:0] sin_p = '0;
  logic [CfgW-1:0]         z_offset_p = '0;
  logic [CfgW-1:0]         noise_p = NOISE_RESET;
  logic [CfgW-1:0]         tick_p = TICK_RESET;
  logic                    x_low_p = 1'b0;
  logic                    z_low_p = 1'b0;
  logic signed [DataW-1:0] last_phase_p = PHASE_ZERO;
  logic [DataW-1:0]        last_time_p = '0;

  quadrant_word_t pending_words[$];
  row_t           directed_rows[$];

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 45;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned samples_sent = 0;
  int unsigned words_seen = 0;
  int unsigned triggers_seen = 0;
  int unsigned rates_seen = 0;
  int unsigned reg_writes = 0;
  logic [DataW-1:0] stamp_now = '0;

  crank_quadrant_schmitt_trigger_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DataW-1:0] clamp_s15(input longint v);
    if (v > 32767) return S15_MAX;
    if (v < -32768) return S15_MIN;
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] fx_mul(input logic signed [DataW-1:0] a,
                                                     input logic signed [DataW-1:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp_s15(prod >>> 15);
  endfunction

  function automatic band_t band_of(input logic signed [DataW-1:0] v);
    longint mag;
    mag = (v < 0) ? longint'(clamp_s15(-longint'(v))) : longint'(v);
    if (mag <= longint'(noise_p)) return BAND_INSIDE;
    return (v > 0) ? BAND_ABOVE : BAND_BELOW;
  endfunction

  function automatic logic next_low(input logic low, input band_t b);
    return low ? (b != BAND_ABOVE) : (b == BAND_BELOW);
  endfunction

  function automatic quadrant_word_t predict_quadrant(input logic signed [DataW-1:0] sx,
                                                      input logic signed [DataW-1:0] sz,
                                                      input logic [DataW-1:0] stamp);
    quadrant_word_t w;
    logic signed [DataW-1:0] ux, uz, lx, lz, zv, diff;
    logic [DataW-1:0] dt;
    logic nx, nz;
    longint secs;
    ux = clamp_s15(longint'(sx) - longint'(bias_x_p));
    uz = clamp_s15(longint'(sz) - longint'(bias_z_p));
    lx = clamp_s15(longint'(fx_mul(cos_p, ux)) - longint'(fx_mul(sin_p, uz)));
    lz = clamp_s15(longint'(fx_mul(cos_p, uz)) + longint'(fx_mul(sin_p, ux)));
    zv = clamp_s15(longint'(lz) + longint'(z_offset_p));
    nx = next_low(x_low_p, band_of(lx));
    nz = next_low(z_low_p, band_of(zv));
    w = '0;
    w.x_flag = nx;
    w.z_flag = nz;
    if (nx != x_low_p || nz != z_low_p) begin
      w.triggered = 1'b1;
      if (nx != x_low_p) begin
        w.phase = nz ? PHASE_ZERO : PHASE_NEG_ONE;
      end else begin
        w.phase = nx ? PHASE_NEG_HALF : PHASE_POS_HALF;
      end
      diff = w.phase - last_phase_p;
      if (diff != 0) begin
        dt = stamp - last_time_p;
        secs = longint'(dt) * longint'(tick_p);
        if (secs > 32767) secs = 32767;
        if (secs == 0) begin
          w.rate = (diff > 0) ? S15_MAX : S15_MIN;
        end else begin
          w.rate = clamp_s15((longint'(diff) * 32768) / secs);
        end
        w.rate_valid = 1'b1;
      end
      last_phase_p = w.phase;
      last_time_p = stamp;
    end
    x_low_p = nx;
    z_low_p = nz;
    return w;
  endfunction

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_sample(input logic signed [DataW-1:0] sx, input logic signed [DataW-1:0] sz,
                            input logic [DataW-1:0] stamp);
    row_t r;
    r = '{kind: ROW_SAMPLE, reg_idx: '0, value: '0, sx: sx, sz: sz, stamp: stamp,
          typed: 1'b0, want: '0};
    directed_rows.push_back(r);
  endtask

  task automatic add_checked(input logic signed [DataW-1:0] sx, input logic signed [DataW-1:0] sz,
                             input logic [DataW-1:0] stamp, input logic trig,
                             input logic signed [DataW-1:0] phase, input logic rv,
                             input logic signed [DataW-1:0] rate, input logic xf, input logic zf);
    row_t r;
    r = '{kind: ROW_SAMPLE, reg_idx: '0, value: '0, sx: sx, sz: sz, stamp: stamp,
          typed: 1'b1, want: '0};
    r.want = '{triggered: trig, phase: phase, rate_valid: rv, rate: rate,
               x_flag: xf, z_flag: zf};
    directed_rows.push_back(r);
  endtask

  task automatic add_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    row_t r;
    r = '{kind: ROW_WRITE, reg_idx: idx, value: val, sx: '0, sz: '0, stamp: '0,
          typed: 1'b0, want: '0};
    directed_rows.push_back(r);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BIAS_X:          bias_x_p = val;
      REG_BIAS_Z:          bias_z_p = val;
      REG_COS_THETA:       cos_p = val;
      REG_SIN_THETA:       sin_p = val;
      REG_Z_OFFSET:        z_offset_p = val[CfgW-1:0];
      REG_NOISE_THRESHOLD: noise_p = val[CfgW-1:0];
      REG_TICK_SECONDS:    tick_p = val[CfgW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [DataW-1:0] sx, input logic signed [DataW-1:0] sz,
                             input logic [DataW-1:0] stamp, input bit typed,
                             input quadrant_word_t typed_word);
    quadrant_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {stamp, sz, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    w = predict_quadrant(sx, sz, stamp);
    pending_words.push_back(typed ? typed_word : w);
    samples_sent++;
  endtask

  task automatic drain(input int unsigned extra);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_batch(input int unsigned batch);
    logic [DataW-1:0] vals [REG_COUNT];
    for (int i = 0; i < REG_COUNT; i++) vals[i] = DataW'($urandom);
    vals[REG_Z_OFFSET] = DataW'($urandom_range(0, 32767));
    vals[REG_NOISE_THRESHOLD] = DataW'($urandom_range(0, 4096));
    vals[REG_TICK_SECONDS] = $urandom_range(0, 1) ? DataW'($urandom_range(1, 64))
                                                  : DataW'($urandom_range(1, 32767));
    case (batch)
      0: vals = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'd328, 16'd1};
      2: vals = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF};
      4: vals = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, vals[5], 16'd1};
      default: ;
    endcase
    for (int i = 0; i < REG_COUNT; i++) write_reg(IdxW'(i), vals[i]);
  endtask

  function automatic logic signed [DataW-1:0] pick_axis();
    int unsigned r;
    int span;
    r = $urandom_range(99);
    span = 2 * int'(noise_p) + 64;
    if (r < 55) return DataW'($urandom);
    if (r < 80) return DataW'(int'($urandom_range(0, 2 * span)) - span);
    case ($urandom_range(2))
      0: return S15_MIN;
      1: return S15_MAX;
      default: return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_words
    quadrant_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.triggered = out_tuser[0];
      got.rate_valid = out_tuser[1];
      got.phase = out_tdata[15:0];
      got.rate = out_tdata[31:16];
      got.x_flag = out_tdata[32];
      got.z_flag = out_tdata[33];
      words_seen++;
      if (got.triggered) triggers_seen++;
      if (got.rate_valid) rates_seen++;
      if (pending_words.size() == 0) begin
        report($sformatf("word with nothing expected: %h / %h", out_tdata, out_tuser));
      end else begin
        want = pending_words.pop_front();
        if (got.triggered !== want.triggered)
          report($sformatf("triggered: got %0b expected %0b", got.triggered, want.triggered));
        if (got.phase !== want.phase)
          report($sformatf("phase: got %0d expected %0d", got.phase, want.phase));
        if (got.rate_valid !== want.rate_valid)
          report($sformatf("rate_valid: got %0b expected %0b", got.rate_valid, want.rate_valid));
        if (got.rate !== want.rate)
          report($sformatf("phase_rate: got %0d expected %0d", got.rate, want.rate));
        if (got.x_flag !== want.x_flag)
          report($sformatf("x_flag: got %0b expected %0b", got.x_flag, want.x_flag));
        if (got.z_flag !== want.z_flag)
          report($sformatf("z_flag: got %0b expected %0b", got.z_flag, want.z_flag));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // default registers
    add_checked(16'sh0000, 16'sh0000, 16'd0, 1'b0, PHASE_ZERO, 1'b0, 16'sh0000, 1'b0, 1'b0);
    add_checked(S15_MIN, 16'sh0000, 16'd10, 1'b1, PHASE_NEG_ONE, 1'b1, S15_MIN, 1'b1, 1'b0);
    add_checked(S15_MIN, 16'sh0000, 16'd20, 1'b0, PHASE_ZERO, 1'b0, 16'sh0000, 1'b1, 1'b0);
    add_checked(16'sh0000, S15_MIN, 16'd10, 1'b1, PHASE_NEG_HALF, 1'b1, S15_MAX, 1'b1, 1'b1);
    add_sample(S15_MAX, S15_MAX, 16'd100);
    add_checked(S15_MIN, S15_MAX, 16'd200, 1'b1, PHASE_NEG_ONE, 1'b0, 16'sh0000, 1'b1, 1'b0);
    add_sample(16'sd329, 16'sh0000, 16'd210);
    add_sample(16'sd330, 16'sh0000, 16'd220);
    add_sample(-16'sd328, 16'sh0000, 16'd230);
    add_sample(-16'sd329, 16'sh0000, 16'd240);
    add_sample(16'sh0000, S15_MIN, 16'd240);
    add_sample(S15_MAX, S15_MAX, 16'd65000);
    add_sample(S15_MIN, S15_MIN, 16'd5);
    add_sample(16'sh0000, S15_MAX, 16'd6);
    add_sample(S15_MAX, 16'sh0000, 16'd7);
    add_sample(16'sh0000, S15_MIN, 16'd9);
    add_sample(16'sh0000, S15_MAX, 16'd30009);
    // zero seconds per tick
    add_write(REG_TICK_SECONDS, 16'd0);
    add_checked(S15_MIN, 16'sh0000, 16'd500, 1'b1, PHASE_NEG_ONE, 1'b1, S15_MAX, 1'b1, 1'b0);
    add_write(REG_TICK_SECONDS, 16'h7FFF);
    add_sample(S15_MIN, S15_MIN, 16'd501);
    // widest noise band
    add_write(REG_NOISE_THRESHOLD, 16'h7FFF);
    add_checked(S15_MAX, S15_MAX, 16'd600, 1'b0, PHASE_ZERO, 1'b0, 16'sh0000, 1'b1, 1'b1);
    add_write(REG_NOISE_THRESHOLD, 16'h0000);
    add_write(REG_BIAS_X, 16'h7FFF);
    add_write(REG_BIAS_Z, 16'h8000);
    add_write(REG_COS_THETA, 16'h8000);
    add_write(REG_SIN_THETA, 16'h8000);
    add_write(REG_Z_OFFSET, 16'h7FFF);
    add_sample(S15_MIN, S15_MAX, 16'd700);
    add_sample(S15_MAX, S15_MIN, 16'd800);
    add_write(REG_UNUSED, 16'hFFFF);
    add_sample(16'sh0000, 16'sh0000, 16'd900);
    add_sample(16'sh5555, -16'sh5556, 16'hAAAA);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain(SETTLE_CYCLES);
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].sx, directed_rows[i].sz, directed_rows[i].stamp,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int b = 0; b < BATCHES; b++) begin
      drain(SETTLE_CYCLES);
      send_idle_pct = (b < 3) ? 36 : ((b < 5) ? 45 : 0);
      recv_idle_pct = (b < 3) ? 45 : ((b < 5) ? 36 : 0);
      program_batch(b);
      for (int n = 0; n < BATCH_WORDS; n++) begin
        // hold until the output side has caught up
        if (b == 1 && n == BATCH_WORDS / 2) drain(0);
        case ($urandom_range(19))
          0, 1, 2:  stamp_now = stamp_now;
          3, 4:     stamp_now = DataW'($urandom);
          default:  stamp_now = stamp_now + DataW'($urandom_range(1, 40));
        endcase
        send_sample(pick_axis(), pick_axis(), stamp_now, 1'b0, '0);
      end
    end

    drain(SETTLE_CYCLES);
    if (pending_words.size() != 0) report($sformatf("%0d words never arrived",
                                                    pending_words.size()));
    $display("Sent %0d samples over %0d register writes; checked %0d words", samples_sent,
             reg_writes, words_seen);
    $display("with %0d triggers and %0d rates.", triggers_seen, rates_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cqst_pkg.sv
rtl/cqst_div.sv
rtl/cqst_dp.sv
rtl/cqst_ctrl.sv
rtl/crank_quadrant_schmitt_trigger_unit.sv
rtl/cqst_checker.sv
tb/sv/tb.sv
